>>> sv/pst_pkg.sv
// constants, types and state codes for the priority schedule timing block
// no dependencies; referenced by scoped name from priority_schedule_timing
`timescale 1ns / 1ps

package pst_pkg;

   localparam int MAX_PROCS = 16;
   localparam int ADDR_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W     = $clog2(MAX_PROCS + 1);
   localparam int REM_W     = CNT_W + 1;

   localparam int BURST_W = 16;
   localparam int PRIO_W  = 8;
   localparam int IDX_W   = 4;
   localparam int TIME_W  = 20;
   localparam int SUM_W   = 24;
   localparam int AVG_W   = 28;
   localparam int FRAC_W  = 8;
   localparam int DIV_W   = SUM_W + FRAC_W;
   localparam int STEP_W  = $clog2(DIV_W);

   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
   localparam logic [AVG_W-1:0]  AVG_MAX  = '1;

   localparam logic RESULT_JOB     = 1'b0;
   localparam logic RESULT_SUMMARY = 1'b1;

   typedef struct packed {
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
      logic [IDX_W-1:0]   idx;
   } job_entry_type;

   typedef enum logic [10:0] {
      ST_LOAD     = 11'b000_0000_0001,
      ST_A_RD     = 11'b000_0000_0010,
      ST_A_GET    = 11'b000_0000_0100,
      ST_B_RD     = 11'b000_0000_1000,
      ST_B_CMP    = 11'b000_0001_0000,
      ST_A_PUT    = 11'b000_0010_0000,
      ST_K_RD     = 11'b000_0100_0000,
      ST_K_OUT    = 11'b000_1000_0000,
      ST_DIV_INIT = 11'b001_0000_0000,
      ST_DIV_STEP = 11'b010_0000_0000,
      ST_SUM      = 11'b100_0000_0000
   } state_type;

endpackage

>>> sv/priority_schedule_timing.sv
// Jobs are loaded one item per cycle while req_ready is high. The item marked
// last starts a run: an all-pairs exchange sort over the n stored jobs is done by
// one compare unit over a job memory with one read port and one write port;
// each schedule entry can then be held by a stall on the result side, and the
// two averages come from one shared restoring divider. A job that arrives with
// MAX_PROCS jobs already stored is dropped. The summary result sits in the
// output register while loading of the next run proceeds.
// depends on pst_pkg
`timescale 1ns / 1ps

module priority_schedule_timing (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_burst_time,
   input  logic [7:0]  req_job_priority,
   input  logic        req_last_job,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [3:0]  rsp_job_index,
   output logic [7:0]  rsp_job_priority_out,
   output logic [19:0] rsp_completion_time,
   output logic [19:0] rsp_waiting_time,
   output logic [23:0] rsp_total_waiting,
   output logic [23:0] rsp_total_turnaround,
   output logic [27:0] rsp_avg_waiting,
   output logic [27:0] rsp_avg_turnaround,
   output logic        rsp_run_end
);

   // job memory
   pst_pkg::job_entry_type mem [pst_pkg::MAX_PROCS];
   pst_pkg::job_entry_type rd_data_ff;
   logic [pst_pkg::ADDR_W-1:0] rd_addr;
   logic                       mem_we;
   logic [pst_pkg::ADDR_W-1:0] mem_waddr;
   pst_pkg::job_entry_type     mem_wdata;

   // control
   pst_pkg::state_type state_ff, state_in;
   logic [pst_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [pst_pkg::CNT_W-1:0]  n_ff, n_in;
   logic [pst_pkg::ADDR_W-1:0] a_ff, a_in;
   logic [pst_pkg::ADDR_W-1:0] b_ff, b_in;
   logic [pst_pkg::ADDR_W-1:0] k_ff, k_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       div_pass_ff, div_pass_in;
   logic [pst_pkg::STEP_W-1:0] step_ff, step_in;

   // datapath
   pst_pkg::job_entry_type     cur_ff, cur_in;
   logic [pst_pkg::TIME_W-1:0] run_ff, run_in;
   logic [pst_pkg::SUM_W-1:0]  sum_w_ff, sum_w_in;
   logic [pst_pkg::SUM_W-1:0]  sum_t_ff, sum_t_in;
   logic [pst_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [pst_pkg::DIV_W-1:0]  quo_ff, quo_in;
   logic [pst_pkg::AVG_W-1:0]  avg_w_ff, avg_w_in;
   logic [pst_pkg::AVG_W-1:0]  avg_t_ff, avg_t_in;

   // result register
   logic        out_load;
   logic        o_kind_ff, o_kind_in;
   logic [3:0]  o_idx_ff, o_idx_in;
   logic [7:0]  o_prio_ff, o_prio_in;
   logic [19:0] o_comp_ff, o_comp_in;
   logic [19:0] o_wait_ff, o_wait_in;
   logic [23:0] o_tw_ff, o_tw_in;
   logic [23:0] o_tt_ff, o_tt_in;
   logic [27:0] o_aw_ff, o_aw_in;
   logic [27:0] o_at_ff, o_at_in;
   logic        o_end_ff, o_end_in;

   logic                        req_fire;
   logic                        slot_free;
   logic                        b_last;
   logic                        a_last;
   logic                        k_last;
   logic [pst_pkg::TIME_W:0]    comp_sum;
   logic [pst_pkg::TIME_W-1:0]  comp_sat;
   logic [pst_pkg::SUM_W:0]     sw_sum;
   logic [pst_pkg::SUM_W:0]     st_sum;
   logic [pst_pkg::SUM_W-1:0]   sw_sat;
   logic [pst_pkg::SUM_W-1:0]   st_sat;
   logic [pst_pkg::REM_W-1:0]   trial;
   logic                        trial_ge;
   logic [pst_pkg::REM_W-1:0]   rem_step;
   logic [pst_pkg::DIV_W-1:0]   quo_step;
   logic [pst_pkg::AVG_W-1:0]   avg_sat;

   assign req_ready = (state_ff == pst_pkg::ST_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign b_last = (pst_pkg::CNT_W'(b_ff) + pst_pkg::CNT_W'(1)) == n_ff;
   assign a_last = (pst_pkg::CNT_W'(a_ff) + pst_pkg::CNT_W'(1)) == n_ff;
   assign k_last = (pst_pkg::CNT_W'(k_ff) + pst_pkg::CNT_W'(1)) == n_ff;

   // saturating accumulate for one schedule entry
   assign comp_sum = {1'b0, run_ff} + (pst_pkg::TIME_W + 1)'(rd_data_ff.burst);
   assign comp_sat = comp_sum[pst_pkg::TIME_W] ? pst_pkg::TIME_MAX
                                               : comp_sum[pst_pkg::TIME_W-1:0];
   assign sw_sum   = {1'b0, sum_w_ff} + (pst_pkg::SUM_W + 1)'(run_ff);
   assign st_sum   = {1'b0, sum_t_ff} + (pst_pkg::SUM_W + 1)'(comp_sat);
   assign sw_sat   = sw_sum[pst_pkg::SUM_W] ? pst_pkg::SUM_MAX : sw_sum[pst_pkg::SUM_W-1:0];
   assign st_sat   = st_sum[pst_pkg::SUM_W] ? pst_pkg::SUM_MAX : st_sum[pst_pkg::SUM_W-1:0];

   // one restoring division step
   assign trial    = {rem_ff[pst_pkg::REM_W-2:0], quo_ff[pst_pkg::DIV_W-1]};
   assign trial_ge = trial >= {1'b0, n_ff};
   assign rem_step = trial_ge ? (trial - {1'b0, n_ff}) : trial;
   assign quo_step = {quo_ff[pst_pkg::DIV_W-2:0], trial_ge};
   assign avg_sat  = (quo_step > pst_pkg::DIV_W'(pst_pkg::AVG_MAX)) ? pst_pkg::AVG_MAX
                                                                  : quo_step[pst_pkg::AVG_W-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      div_pass_in  = div_pass_ff;
      step_in      = step_ff;
      cur_in       = cur_ff;
      run_in       = run_ff;
      sum_w_in     = sum_w_ff;
      sum_t_in     = sum_t_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      avg_w_in     = avg_w_ff;
      avg_t_in     = avg_t_ff;
      rd_addr      = a_ff;
      mem_we       = 1'b0;
      mem_waddr    = b_ff;
      mem_wdata    = cur_ff;
      out_load     = 1'b0;
      o_kind_in    = pst_pkg::RESULT_JOB;
      o_idx_in     = '0;
      o_prio_in    = '0;
      o_comp_in    = '0;
      o_wait_in    = '0;
      o_tw_in      = '0;
      o_tt_in      = '0;
      o_aw_in      = '0;
      o_at_in      = '0;
      o_end_in     = 1'b0;

      case (state_ff)
         pst_pkg::ST_LOAD: begin
            if (req_fire) begin
               if (count_ff < pst_pkg::CNT_W'(pst_pkg::MAX_PROCS)) begin
                  mem_we          = 1'b1;
                  mem_waddr       = pst_pkg::ADDR_W'(count_ff);
                  mem_wdata.burst = req_burst_time;
                  mem_wdata.prio  = req_job_priority;
                  mem_wdata.idx   = pst_pkg::IDX_W'(count_ff);
                  count_in        = count_ff + pst_pkg::CNT_W'(1);
               end
               if (req_last_job) begin
                  n_in     = (count_ff < pst_pkg::CNT_W'(pst_pkg::MAX_PROCS))
                             ? count_ff + pst_pkg::CNT_W'(1) : count_ff;
                  a_in     = '0;
                  state_in = pst_pkg::ST_A_RD;
               end
            end
         end
         pst_pkg::ST_A_RD: begin
            rd_addr  = a_ff;
            state_in = pst_pkg::ST_A_GET;
         end
         pst_pkg::ST_A_GET: begin
            cur_in   = rd_data_ff;
            b_in     = '0;
            state_in = pst_pkg::ST_B_RD;
         end
         pst_pkg::ST_B_RD: begin
            rd_addr  = b_ff;
            state_in = pst_pkg::ST_B_CMP;
         end
         pst_pkg::ST_B_CMP: begin
            // entry a lives in cur; exchange with entry b when b has the higher priority
            if ((b_ff != a_ff) && (cur_ff.prio < rd_data_ff.prio)) begin
               mem_we    = 1'b1;
               mem_waddr = b_ff;
               mem_wdata = cur_ff;
               cur_in    = rd_data_ff;
            end
            if (b_last) begin
               state_in = pst_pkg::ST_A_PUT;
            end else begin
               b_in     = b_ff + pst_pkg::ADDR_W'(1);
               state_in = pst_pkg::ST_B_RD;
            end
         end
         pst_pkg::ST_A_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = a_ff;
            mem_wdata = cur_ff;
            if (a_last) begin
               k_in     = '0;
               run_in   = '0;
               sum_w_in = '0;
               sum_t_in = '0;
               state_in = pst_pkg::ST_K_RD;
            end else begin
               a_in     = a_ff + pst_pkg::ADDR_W'(1);
               state_in = pst_pkg::ST_A_RD;
            end
         end
         pst_pkg::ST_K_RD: begin
            rd_addr  = k_ff;
            state_in = pst_pkg::ST_K_OUT;
         end
         pst_pkg::ST_K_OUT: begin
            // keep entry k on the read port while the result side stalls
            rd_addr = k_ff;
            if (slot_free) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               o_idx_in     = rd_data_ff.idx;
               o_prio_in    = rd_data_ff.prio;
               o_comp_in    = comp_sat;
               o_wait_in    = run_ff;
               run_in       = comp_sat;
               sum_w_in     = sw_sat;
               sum_t_in     = st_sat;
               if (k_last) begin
                  div_pass_in = 1'b0;
                  state_in    = pst_pkg::ST_DIV_INIT;
               end else begin
                  k_in     = k_ff + pst_pkg::ADDR_W'(1);
                  state_in = pst_pkg::ST_K_RD;
               end
            end
         end
         pst_pkg::ST_DIV_INIT: begin
            rem_in   = '0;
            step_in  = '0;
            quo_in   = div_pass_ff ? {sum_t_ff, pst_pkg::FRAC_W'(0)}
                                   : {sum_w_ff, pst_pkg::FRAC_W'(0)};
            state_in = pst_pkg::ST_DIV_STEP;
         end
         pst_pkg::ST_DIV_STEP: begin
            rem_in  = rem_step;
            quo_in  = quo_step;
            step_in = step_ff + pst_pkg::STEP_W'(1);
            if (step_ff == pst_pkg::STEP_W'(pst_pkg::DIV_W - 1)) begin
               if (div_pass_ff) begin
                  avg_t_in = avg_sat;
                  state_in = pst_pkg::ST_SUM;
               end else begin
                  avg_w_in    = avg_sat;
                  div_pass_in = 1'b1;
                  state_in    = pst_pkg::ST_DIV_INIT;
               end
            end
         end
         pst_pkg::ST_SUM: begin
            if (slot_free) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               o_kind_in    = pst_pkg::RESULT_SUMMARY;
               o_tw_in      = sum_w_ff;
               o_tt_in      = sum_t_ff;
               o_aw_in      = avg_w_ff;
               o_at_in      = avg_t_ff;
               o_end_in     = 1'b1;
               count_in     = '0;
               run_in       = '0;
               sum_w_in     = '0;
               sum_t_in     = '0;
               state_in     = pst_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = pst_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pst_pkg::ST_LOAD;
         count_ff     <= '0;
         n_ff         <= '0;
         a_ff         <= '0;
         b_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         div_pass_ff  <= 1'b0;
         step_ff      <= '0;
         run_ff       <= '0;
         sum_w_ff     <= '0;
         sum_t_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         n_ff         <= n_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         div_pass_ff  <= div_pass_in;
         step_ff      <= step_in;
         run_ff       <= run_in;
         sum_w_ff     <= sum_w_in;
         sum_t_ff     <= sum_t_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      avg_w_ff <= avg_w_in;
      avg_t_ff <= avg_t_in;
      if (out_load) begin
         o_kind_ff <= o_kind_in;
         o_idx_ff  <= o_idx_in;
         o_prio_ff <= o_prio_in;
         o_comp_ff <= o_comp_in;
         o_wait_ff <= o_wait_in;
         o_tw_ff   <= o_tw_in;
         o_tt_ff   <= o_tt_in;
         o_aw_ff   <= o_aw_in;
         o_at_ff   <= o_at_in;
         o_end_ff  <= o_end_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_kind      = o_kind_ff;
   assign rsp_job_index        = o_idx_ff;
   assign rsp_job_priority_out = o_prio_ff;
   assign rsp_completion_time  = o_comp_ff;
   assign rsp_waiting_time     = o_wait_ff;
   assign rsp_total_waiting    = o_tw_ff;
   assign rsp_total_turnaround = o_tt_ff;
   assign rsp_avg_waiting      = o_aw_ff;
   assign rsp_avg_turnaround   = o_at_ff;
   assign rsp_run_end          = o_end_ff;

   // store never overfills
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= pst_pkg::CNT_W'(pst_pkg::MAX_PROCS))
      else $error("job count beyond store depth");

   // a pending result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register loaded while occupied");

   // a run never works on an empty set
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != pst_pkg::ST_LOAD) |-> (n_ff != '0))
      else $error("run started with no jobs");

   // summary closes the run and clears the store count
   assert property (@(posedge clock) disable iff (reset)
      (out_load && o_end_in) |=> (count_ff == '0 && state_ff == pst_pkg::ST_LOAD))
      else $error("run state not cleared after summary");

   // memory written only while loading or sorting
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == pst_pkg::ST_LOAD || state_ff == pst_pkg::ST_B_CMP
                  || state_ff == pst_pkg::ST_A_PUT))
      else $error("job memory written outside load or sort");

endmodule
